/* design/triangle_pair_exp_kernel_eval_defines.svh */
// Assertion macros shared by the kernel evaluator.
`ifndef TRIANGLE_PAIR_EXP_KERNEL_EVAL_DEFINES_SVH
`define TRIANGLE_PAIR_EXP_KERNEL_EVAL_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TPK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpk assertion failed");

// Next-cycle implication, checked out of reset.
`define TPK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpk assertion failed");

`endif

/* design/tpk_eval_pkg.sv */
`timescale 1ns / 1ps
package tpk_eval_pkg;

  localparam int CoordW    = 32;
  localparam int WFrac     = 16;
  localparam int WeightW   = WFrac + 1;
  localparam int KernelW   = 17;
  // signed weight including a0 = 1 - a1 - a2
  localparam int SWeightW  = WFrac + 3;
  localparam int ProdW     = SWeightW + CoordW;
  localparam int PartW     = ProdW - WFrac;
  localparam int PointW    = PartW + 2;
  localparam int DiffW     = PointW + 1;
  localparam int MagW      = 20;
  localparam int SqW       = 2 * MagW;
  localparam int SumW      = SqW + 2;
  localparam int RootW     = SumW / 2;
  localparam int RemW      = RootW + 3;
  localparam int TW        = RootW + 7;
  localparam int EW        = 32;
  localparam int NumSq     = 8;
  localparam int NumSlots  = 6;

  localparam logic [DiffW-1:0] FarLimit = DiffW'(12) << 16;
  localparam logic [31:0]      Recip3   = 32'hAAAA_AAAB;
  localparam logic [EW-1:0]    EOne     = EW'(1) << 31;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                      operation;
    logic [2:0]               vertex_slot;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [WeightW-1:0]       weight_a1;
    logic [WeightW-1:0]       weight_a2;
    logic [WeightW-1:0]       weight_b1;
    logic [WeightW-1:0]       weight_b2;
    logic                     last_point;
  } in_t;

  typedef struct packed {
    logic [KernelW-1:0] kernel_value;
    logic               run_end;
  } out_t;

  // control bits that ride along each stage
  typedef struct packed {
    logic valid;
    logic far;
    logic run_end;
  } ctl_t;

endpackage

/* design/triangle_pair_exp_kernel_eval.sv */
`timescale 1ns / 1ps
`include "triangle_pair_exp_kernel_eval_defines.svh"
// Exponential kernel exp(-|x-y|) at quadrature points of a triangle pair.
// Store transfers (operation 0) load one vertex into slot 0-5 and give no
// result; evaluate transfers (operation 1) give one kernel_value in Q1.16,
// in order. The block takes one transfer every cycle while the output is not
// stalled; the whole pipeline (weight products, point difference, squares, a
// 21-stage bit-per-stage square root, a Taylor series and eight squaring
// stages) advances together and holds only while the output is stalled. A
// store is seen by every evaluate transferred after it.
module triangle_pair_exp_kernel_eval (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tpk_eval_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tpk_eval_pkg::out_t  out_data_o
);
  import tpk_eval_pkg::*;

  logic en;
  logic in_xfer;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign in_xfer    = in_valid_i && en;

  // ---------------- vertex store ----------------
  logic signed [CoordW-1:0] vtx_q [NumSlots][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumSlots; s++) begin
        for (int c = 0; c < 3; c++) vtx_q[s][c] <= '0;
      end
    end else if (in_xfer && in_data_i.operation == OP_STORE &&
                 in_data_i.vertex_slot < 3'(NumSlots)) begin
      vtx_q[in_data_i.vertex_slot][0] <= in_data_i.coord_x;
      vtx_q[in_data_i.vertex_slot][1] <= in_data_i.coord_y;
      vtx_q[in_data_i.vertex_slot][2] <= in_data_i.coord_z;
    end
  end

  // ---------------- stage 1: weight times coordinate ----------------
  logic signed [SWeightW-1:0] w_d [2][3];
  logic signed [ProdW-1:0]    prod_q [2][3][3];
  ctl_t c1_q;

  always_comb begin
    w_d[0][1] = $signed(SWeightW'(in_data_i.weight_a1));
    w_d[0][2] = $signed(SWeightW'(in_data_i.weight_a2));
    w_d[1][1] = $signed(SWeightW'(in_data_i.weight_b1));
    w_d[1][2] = $signed(SWeightW'(in_data_i.weight_b2));
    w_d[0][0] = $signed(SWeightW'(1) << WFrac) - w_d[0][1] - w_d[0][2];
    w_d[1][0] = $signed(SWeightW'(1) << WFrac) - w_d[1][1] - w_d[1][2];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int t = 0; t < 2; t++) begin
        for (int k = 0; k < 3; k++) begin
          for (int c = 0; c < 3; c++) begin
            prod_q[t][k][c] <= ProdW'(w_d[t][k]) * ProdW'(vtx_q[3*t+k][c]);
          end
        end
      end
    end
  end

  // ---------------- stage 2: points, difference, magnitude ----------------
  logic [MagW-1:0] mag_q [3];
  ctl_t c2_q;
  logic [MagW-1:0] mag_d [3];
  logic            far_d;

  always_comb begin
    logic signed [PointW-1:0] px, py;
    logic signed [DiffW-1:0]  u;
    logic [DiffW-1:0]         m;
    far_d = 1'b0;
    for (int c = 0; c < 3; c++) begin
      // arithmetic shift gives floor division by 2^WFrac
      px = PointW'(prod_q[0][0][c] >>> WFrac) + PointW'(prod_q[0][1][c] >>> WFrac)
         + PointW'(prod_q[0][2][c] >>> WFrac);
      py = PointW'(prod_q[1][0][c] >>> WFrac) + PointW'(prod_q[1][1][c] >>> WFrac)
         + PointW'(prod_q[1][2][c] >>> WFrac);
      u  = DiffW'(px) - DiffW'(py);
      m  = u[DiffW-1] ? DiffW'(-u) : DiffW'(u);
      if (m >= FarLimit) far_d = 1'b1;
      mag_d[c] = m[MagW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) mag_q[c] <= mag_d[c];
    end
  end

  // ---------------- stage 3: squares ----------------
  logic [SqW-1:0] sq_q [3];
  ctl_t c3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) sq_q[c] <= SqW'(mag_q[c]) * SqW'(mag_q[c]);
    end
  end

  // ---------------- stage 4: sum of squares ----------------
  logic [SumW-1:0] sum_q;
  ctl_t c4_q;

  always_ff @(posedge clk_i) begin
    if (en) sum_q <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
  end

  // ---------------- square root, one result bit per stage ----------------
  logic [RemW-1:0]  sr_rem_q  [RootW];
  logic [RootW-1:0] sr_root_q [RootW];
  logic [SumW-1:0]  sr_n_q    [RootW];
  ctl_t             sr_c_q    [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_sqrt
    localparam int Bit = RootW - 1 - s;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [SumW-1:0]  n_in;
    logic [RemW+1:0]  rem_sh;
    logic [RemW+1:0]  trial;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = sum_q;
    end else begin : g_rest
      assign rem_in  = sr_rem_q[s-1];
      assign root_in = sr_root_q[s-1];
      assign n_in    = sr_n_q[s-1];
    end

    assign rem_sh = {rem_in, n_in[2*Bit+1 -: 2]};
    assign trial  = {3'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_n_q[s] <= n_in;
        if (rem_sh >= trial) begin
          sr_rem_q[s]  <= RemW'(rem_sh - trial);
          sr_root_q[s] <= {root_in[RootW-2:0], 1'b1};
        end else begin
          sr_rem_q[s]  <= RemW'(rem_sh);
          sr_root_q[s] <= {root_in[RootW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- exp series ----------------
  logic [TW-1:0]  x1_t_q, x2_t_q, x3_t_q, x4_t_q;
  logic [TW-1:0]  x1_t2_q, x2_t2_q, x3_t2_q, x4_t2_q;
  logic [TW-1:0]  x2_t3_q, x3_t3_q;
  logic [TW-1:0]  x3_t4_q;
  logic [31:0]    x4_q6_q, x4_q24_q;
  logic [EW-1:0]  e_q [NumSq+1];
  ctl_t x1_c_q, x2_c_q, x3_c_q, x4_c_q;
  ctl_t e_c_q [NumSq+1];
  logic [TW-1:0]  t_in;
  logic [2*TW-1:0] m1_d, m2_d, m3_d;
  logic [63:0]    d6_d, d24_d;

  assign t_in = {sr_root_q[RootW-1], 7'b0};
  assign m1_d = (2*TW)'(t_in) * (2*TW)'(t_in);
  assign m2_d = (2*TW)'(x1_t2_q) * (2*TW)'(x1_t_q);
  assign m3_d = (2*TW)'(x2_t3_q) * (2*TW)'(x2_t_q);
  // t3/6 = floor(floor(t3/2)/3), t4/24 = floor(floor(t4/8)/3)
  assign d6_d  = 64'(x3_t3_q >> 1) * 64'(Recip3);
  assign d24_d = 64'(x3_t4_q >> 3) * 64'(Recip3);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_t_q  <= t_in;
      x1_t2_q <= TW'(m1_d >> 31);
      x2_t_q  <= x1_t_q;
      x2_t2_q <= x1_t2_q;
      x2_t3_q <= TW'(m2_d >> 31);
      x3_t_q  <= x2_t_q;
      x3_t2_q <= x2_t2_q;
      x3_t3_q <= x2_t3_q;
      x3_t4_q <= TW'(m3_d >> 31);
      x4_t_q  <= x3_t_q;
      x4_t2_q <= x3_t2_q;
      x4_q6_q <= 32'(d6_d >> 33);
      x4_q24_q <= 32'(d24_d >> 33);
      e_q[0]  <= EOne + EW'(x4_t2_q >> 1) + x4_q24_q - EW'(x4_t_q) - x4_q6_q;
    end
  end

  // eight squaring stages
  for (genvar k = 0; k < NumSq; k++) begin : g_sq
    logic [2*EW-1:0] p;
    assign p = (2*EW)'(e_q[k]) * (2*EW)'(e_q[k]);
    always_ff @(posedge clk_i) begin
      if (en) e_q[k+1] <= EW'(p >> 31);
    end
  end

  // ---------------- output register ----------------
  out_t out_q;
  ctl_t out_c_q;
  logic [EW-1:0] rnd_d;
  assign rnd_d = (e_q[NumSq] + EW'(1 << 14)) >> 15;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.kernel_value <= e_c_q[NumSq].far ? '0 : rnd_d[KernelW-1:0];
      out_q.run_end      <= e_c_q[NumSq].run_end;
    end
  end

  // ---------------- control chain ----------------
  ctl_t c0_d;
  assign c0_d = '{valid:   in_xfer && in_data_i.operation == OP_EVAL,
                  far:     1'b0,
                  run_end: in_data_i.last_point};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0; c2_q <= '0; c3_q <= '0; c4_q <= '0;
      for (int s = 0; s < RootW; s++) sr_c_q[s] <= '0;
      x1_c_q <= '0; x2_c_q <= '0; x3_c_q <= '0; x4_c_q <= '0;
      for (int k = 0; k <= NumSq; k++) e_c_q[k] <= '0;
      out_c_q <= '0;
    end else if (en) begin
      c1_q <= c0_d;
      c2_q <= '{valid: c1_q.valid, far: far_d, run_end: c1_q.run_end};
      c3_q <= c2_q;
      c4_q <= c3_q;
      sr_c_q[0] <= c4_q;
      for (int s = 1; s < RootW; s++) sr_c_q[s] <= sr_c_q[s-1];
      x1_c_q <= sr_c_q[RootW-1];
      x2_c_q <= x1_c_q;
      x3_c_q <= x2_c_q;
      x4_c_q <= x3_c_q;
      e_c_q[0] <= x4_c_q;
      for (int k = 1; k <= NumSq; k++) e_c_q[k] <= e_c_q[k-1];
      out_c_q <= e_c_q[NumSq];
    end
  end

  assign out_valid_o = out_c_q.valid;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  `TPK_ASSERT_NEXT(a_eval_enters, in_xfer && in_data_i.operation == OP_EVAL, c1_q.valid)
  `TPK_ASSERT_NOW(a_far_is_zero, out_c_q.valid && out_c_q.far, out_q.kernel_value == '0)
  `TPK_ASSERT_NEXT(a_bad_slot_ignored,
    in_xfer && in_data_i.operation == OP_STORE && in_data_i.vertex_slot > 3'(NumSlots - 1),
    $stable(vtx_q[0][0]) && $stable(vtx_q[5][2]))
  `TPK_ASSERT_NEXT(a_stall_holds_tail, !en, $stable(e_c_q[NumSq]) && $stable(out_c_q))

endmodule
